FILE: design/buset_pkg.sv
// Shared types and constants for the bounded unique set block.
package buset_pkg;

   // Default sizing of the store.
   localparam int DEF_CAPACITY    = 64;
   localparam int DEF_VALUE_WIDTH = 32;

   // Fixed port widths.
   localparam int OP_WIDTH         = 2;
   localparam int VALUE_PORT_WIDTH = 32;
   localparam int COUNT_PORT_WIDTH = 7;

   // Operation codes carried on the request channel.
   localparam logic [OP_WIDTH-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_WIDTH-1:0] OP_DELETE = 2'd1;
   localparam logic [OP_WIDTH-1:0] OP_QUERY  = 2'd2;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CMP,
      ST_UPDATE,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_RESP
   } state_type;

endpackage

FILE: design/bounded_unique_set.sv
// Bounded unique set: a packed store of distinct values with insert, delete and lookup.
//
// The block keeps up to CAPACITY distinct values packed at the front of one
// single-port-write, registered-read memory, together with an element count.
// Each request beat asks to insert, delete or look up one value (only its low
// VALUE_WIDTH bits count; op code 3 acts as a lookup), and each request yields
// exactly one response beat that tells whether the value was present before
// the operation, whether an insert of a new value was refused because the
// store was full, the count after the operation (low 7 bits) and an echo of
// batch_end. One request is worked on at a time, and the memory's single
// read port sets its pace: a linear search reads and then compares each
// entry examined, a search that misses makes one more read to find the end
// of the valid entries, a delete moves each later entry down with a further
// read and write per entry, and accept, update and response are steps of
// their own. The block takes a new request as soon as the previous response
// is in the output register, even while that beat still waits on rsp_stall.
// No clearing pass is needed after reset: the contents of entries at or above
// the count are never used.
module bounded_unique_set
   import buset_pkg::*;
#(
   parameter int CAPACITY    = DEF_CAPACITY,
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
   input  logic                        clock,
   input  logic                        reset,
   // Request channel.
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [OP_WIDTH-1:0]         req_op,
   input  logic [VALUE_PORT_WIDTH-1:0] req_value,
   input  logic                        req_batch_end,
   // Response channel.
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_was_present,
   output logic                        rsp_full_refused,
   output logic [COUNT_PORT_WIDTH-1:0] rsp_count,
   output logic                        rsp_batch_last
);

   // Address width of the store, and count width able to hold CAPACITY itself.
   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   // The count is reported in its low bits; this width covers both sides.
   localparam int EXT_W  = (CNT_W > COUNT_PORT_WIDTH) ? CNT_W : COUNT_PORT_WIDTH;
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   // ------------------------------------------------------------------
   // State.
   // ------------------------------------------------------------------
   state_type state_ff, state_in;

   logic [OP_WIDTH-1:0]    op_ff, op_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   logic                   last_ff, last_in;
   logic [CNT_W-1:0]       idx_ff, idx_in;
   logic                   found_ff, found_in;
   logic                   refused_ff, refused_in;
   logic [CNT_W-1:0]       count_ff, count_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_was_present_ff, rsp_was_present_in;
   logic                        rsp_full_refused_ff, rsp_full_refused_in;
   logic [COUNT_PORT_WIDTH-1:0] rsp_count_ff, rsp_count_in;
   logic                        rsp_batch_last_ff, rsp_batch_last_in;

   // The store and its registered read data.
   logic [VALUE_WIDTH-1:0] entries_ff [CAPACITY];
   logic [VALUE_WIDTH-1:0] rdata_ff;

   // Memory controls from the sequencer.
   logic                   mem_we;
   logic [ADDR_W-1:0]      mem_waddr;
   logic [VALUE_WIDTH-1:0] mem_wdata;
   logic [ADDR_W-1:0]      mem_raddr;

   logic             req_accept;
   logic             rsp_slot_free;
   logic [CNT_W-1:0] idx_plus1;
   logic [CNT_W-1:0] idx_plus2;
   logic [EXT_W-1:0] count_ext;

   assign req_accept    = req_valid && !req_stall;
   assign rsp_slot_free = !rsp_valid_ff || !rsp_stall;
   assign idx_plus1     = idx_ff + 1'b1;
   assign idx_plus2     = idx_plus1 + 1'b1;
   assign count_ext     = EXT_W'(count_ff);

   // ------------------------------------------------------------------
   // Next state.
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            // The search ends without a hit once every valid entry was seen.
            if (idx_ff == count_ff) state_in = ST_UPDATE;
            else                    state_in = ST_CMP;
         end
         ST_CMP: begin
            if (rdata_ff == val_ff) state_in = ST_UPDATE;
            else                    state_in = ST_SCAN;
         end
         ST_UPDATE: begin
            if (op_ff == OP_DELETE && found_ff && idx_plus1 < count_ff) state_in = ST_SHIFT_RD;
            else                                                         state_in = ST_RESP;
         end
         ST_SHIFT_RD: begin
            state_in = ST_SHIFT_WR;
         end
         ST_SHIFT_WR: begin
            if (idx_plus2 < count_ff) state_in = ST_SHIFT_RD;
            else                      state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_slot_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Sequencer outputs: handshake and memory port controls.
   // ------------------------------------------------------------------
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      mem_we    = 1'b0;
      mem_waddr = idx_ff[ADDR_W-1:0];
      mem_wdata = rdata_ff;
      mem_raddr = idx_ff[ADDR_W-1:0];
      case (state_ff)
         ST_UPDATE: begin
            // An absent value is appended behind the last valid entry.
            if (op_ff == OP_INSERT && !found_ff && count_ff < CAP_CNT) begin
               mem_we    = 1'b1;
               mem_waddr = count_ff[ADDR_W-1:0];
               mem_wdata = val_ff;
            end
         end
         ST_SHIFT_RD: begin
            mem_raddr = idx_plus1[ADDR_W-1:0];
         end
         ST_SHIFT_WR: begin
            // The later neighbor read last cycle moves down into this slot.
            mem_we = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Datapath next values.
   // ------------------------------------------------------------------
   always_comb begin
      op_in      = op_ff;
      val_in     = val_ff;
      last_in    = last_ff;
      idx_in     = idx_ff;
      found_in   = found_ff;
      refused_in = refused_ff;
      count_in   = count_ff;

      rsp_valid_in        = rsp_valid_ff && rsp_stall;
      rsp_was_present_in  = rsp_was_present_ff;
      rsp_full_refused_in = rsp_full_refused_ff;
      rsp_count_in        = rsp_count_ff;
      rsp_batch_last_in   = rsp_batch_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               op_in      = req_op;
               val_in     = VALUE_WIDTH'(req_value);
               last_in    = req_batch_end;
               idx_in     = '0;
               found_in   = 1'b0;
               refused_in = 1'b0;
            end
         end
         ST_CMP: begin
            if (rdata_ff == val_ff) found_in = 1'b1;
            else                    idx_in   = idx_plus1;
         end
         ST_UPDATE: begin
            case (op_ff)
               OP_INSERT: begin
                  if (!found_ff) begin
                     if (count_ff < CAP_CNT) count_in   = count_ff + 1'b1;
                     else                    refused_in = 1'b1;
                  end
               end
               OP_DELETE: begin
                  // With no later entry to move, the delete is done here.
                  if (found_ff && !(idx_plus1 < count_ff)) count_in = count_ff - 1'b1;
               end
               default: begin
               end
            endcase
         end
         ST_SHIFT_WR: begin
            idx_in = idx_plus1;
            if (!(idx_plus2 < count_ff)) count_in = count_ff - 1'b1;
         end
         ST_RESP: begin
            if (rsp_slot_free) begin
               rsp_valid_in        = 1'b1;
               rsp_was_present_in  = found_ff;
               rsp_full_refused_in = refused_ff;
               rsp_count_in        = count_ext[COUNT_PORT_WIDTH-1:0];
               rsp_batch_last_in   = last_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Registers.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff               <= op_in;
      val_ff              <= val_in;
      last_ff             <= last_in;
      idx_ff              <= idx_in;
      found_ff            <= found_in;
      refused_ff          <= refused_in;
      rsp_was_present_ff  <= rsp_was_present_in;
      rsp_full_refused_ff <= rsp_full_refused_in;
      rsp_count_ff        <= rsp_count_in;
      rsp_batch_last_ff   <= rsp_batch_last_in;
   end

   // The store: one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) entries_ff[mem_waddr] <= mem_wdata;
      rdata_ff <= entries_ff[mem_raddr];
   end

   // ------------------------------------------------------------------
   // Outputs.
   // ------------------------------------------------------------------
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_was_present  = rsp_was_present_ff;
   assign rsp_full_refused = rsp_full_refused_ff;
   assign rsp_count        = rsp_count_ff;
   assign rsp_batch_last   = rsp_batch_last_ff;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------

   // The count never grows past the capacity of the store.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_CNT)
      else $error("element count exceeds capacity");

   // The search never looks beyond the valid entries.
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_CMP) |-> idx_ff <= count_ff)
      else $error("search index beyond element count");

   // A new response beat is loaded only when the sequencer leaves its response state.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_RESP)
      else $error("response raised outside the response state");

   // A refusal is reported only for a value that was absent.
   a_refuse_absent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_full_refused_ff) |-> !rsp_was_present_ff)
      else $error("refusal reported for a present value");

endmodule
